// ===== rtl/mmdp_pkg.sv =====
package mmdp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 16;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int MODE_W = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 36;
    localparam int CFG_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 24;  // row, col, value
    localparam int OUT_DATA_W = 48;  // product, out_row, out_col, zero fill

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 5'd16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // Request kinds carried on the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_PRODUCT = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;   // start a new dot product
        logic vld;   // element pair on the read data is live
        logic last;  // final pair of the dot product
    } t_mac_ctl;

endpackage

// ===== rtl/mmdp_mem.sv =====
module mmdp_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, shared address: a write and a registered read can both happen each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mmdp_mac.sv =====
module mmdp_mac #(
    parameter int ELEM_WIDTH = mmdp_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mmdp_pkg::t_mac_ctl          i_ctl,
    input  logic [ELEM_WIDTH-1:0]       i_a,
    input  logic [ELEM_WIDTH-1:0]       i_b,
    output logic [mmdp_pkg::PROD_W-1:0] o_acc,
    output logic                        o_done
);
    import mmdp_pkg::*;

    localparam int MUL_W = 2 * ELEM_WIDTH;

    logic signed [MUL_W-1:0] r_mul;
    logic                    r_mul_vld;
    logic                    r_mul_last;
    logic [PROD_W-1:0]       r_acc;
    logic                    r_done;
    logic signed [MUL_W-1:0] mul;
    logic [PROD_W-1:0]       mul_ext;

    assign mul     = $signed(i_a) * $signed(i_b);
    assign mul_ext = PROD_W'(r_mul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld  <= 1'b0;
            r_mul_last <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_mul_vld  <= i_ctl.vld;
            r_mul_last <= i_ctl.vld && i_ctl.last;
            r_done     <= r_mul_vld && r_mul_last;
        end
    end

    // Product stage, then accumulate; sum wraps at the accumulator width
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_mul <= mul;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + mul_ext;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ===== rtl/matrix_multiply_dot_product.sv =====
// Loads (A or B element) produce no result.
// A product request holds the input not ready until its result enters the output register
// (inner_len saturated at MAX_DIM): one element pair per cycle from the single-port stores,
// then read, multiply and accumulate drain; an output stall delays the result's entry.
// Out-of-range or zero inner_len: the result goes out without reading the stores.
// Synchronous active-low reset clears control, sets sizes to 16; stores are not cleared.
module matrix_multiply_dot_product #(
    parameter int MAX_DIM    = mmdp_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mmdp_pkg::ELEM_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mmdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mmdp_pkg::CFG_W-1:0]      i_cfg_data,
    // request stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [mmdp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
    input  logic [mmdp_pkg::MODE_W-1:0]     i_s_axis_tuser,  // mode[1:0]
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [mmdp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // product[35:0], out_row[39:36],
                                                             // out_col[43:40], zero[47:44]
    output logic                            o_m_axis_tuser   // range_error[0]
);
    import mmdp_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIZE_W  = $clog2(MAX_DIM + 1);
    localparam int PAD_W   = OUT_DATA_W - PROD_W - 2 * IDX_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_rows_a;
    logic [CFG_W-1:0] r_inner_len;
    logic [CFG_W-1:0] r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_SIZE_RESET;
            r_inner_len <= CFG_SIZE_RESET;
            r_cols_b    <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_LEN: r_inner_len <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:       ;  // unused index: drop the write
            endcase
        end
    end

    // Effective sizes: register values above MAX_DIM saturate
    logic [SIZE_W-1:0] eff_r;
    logic [SIZE_W-1:0] eff_k;
    logic [SIZE_W-1:0] eff_c;

    assign eff_r = (32'(r_rows_a) > 32'(MAX_DIM))    ? SIZE_W'(MAX_DIM) : SIZE_W'(r_rows_a);
    assign eff_k = (32'(r_inner_len) > 32'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : SIZE_W'(r_inner_len);
    assign eff_c = (32'(r_cols_b) > 32'(MAX_DIM))    ? SIZE_W'(MAX_DIM) : SIZE_W'(r_cols_b);

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] in_row;
    logic [IDX_W-1:0] in_col;
    logic [VAL_W-1:0] in_value;
    t_mode            in_mode;
    logic             in_accept;
    logic             row_lt_r, row_lt_k, col_lt_k, col_lt_c;
    logic             we_a, we_b, req_prod, req_err;

    assign in_row   = i_s_axis_tdata[IDX_W-1:0];
    assign in_col   = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = i_s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    assign in_mode  = t_mode'(i_s_axis_tuser);

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign row_lt_r = 32'(in_row) < 32'(eff_r);
    assign row_lt_k = 32'(in_row) < 32'(eff_k);
    assign col_lt_k = 32'(in_col) < 32'(eff_k);
    assign col_lt_c = 32'(in_col) < 32'(eff_c);

    always_comb begin
        we_a     = 1'b0;
        we_b     = 1'b0;
        req_prod = 1'b0;
        case (in_mode)
            MODE_LOAD_A:  we_a     = in_accept && row_lt_r && col_lt_k;
            MODE_LOAD_B:  we_b     = in_accept && row_lt_k && col_lt_c;
            MODE_PRODUCT: req_prod = in_accept;
            default:      ;  // unused mode: accept and drop
        endcase
    end

    assign req_err = !(row_lt_r && col_lt_c);

    // Load value wraps to the element width
    logic [31:0]           value_ext;
    logic [ELEM_WIDTH-1:0] elem_wdata;

    assign value_ext  = 32'($signed(in_value));
    assign elem_wdata = value_ext[ELEM_WIDTH-1:0];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic              r_err;
    logic [SIZE_W-1:0] r_nk;
    logic [SIZE_W-1:0] r_y;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              run_re;
    logic              run_last;
    logic              emit_load;
    logic              mac_done;

    assign run_last = (r_y == r_nk - SIZE_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_prod) begin
                    n_state = (req_err || eff_k == '0) ? ST_EMIT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        run_re          = 1'b0;
        emit_load       = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_s_axis_tready = 1'b1;
            ST_RUN:   run_re          = 1'b1;
            ST_DRAIN: ;
            ST_EMIT:  emit_load       = !o_m_axis_tvalid || i_m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_y       <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= run_re;
            r_rd_last <= run_re && run_last;
            if (req_prod) begin
                r_y <= '0;
            end else if (run_re) begin
                r_y <= r_y + SIZE_W'(1);
            end
        end
    end

    // Hold the request for the whole dot product
    always_ff @(posedge i_clk) begin
        if (req_prod) begin
            r_row <= in_row;
            r_col <= in_col;
            r_err <= req_err;
            r_nk  <= eff_k;
        end
    end

    // ---------------------------------------------------------------
    // Element stores: write on a load, read one pair per cycle in RUN
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0]     addr_a;
    logic [ADDR_W-1:0]     addr_b;
    logic [ELEM_WIDTH-1:0] rdata_a;
    logic [ELEM_WIDTH-1:0] rdata_b;

    always_comb begin
        if (run_re) begin
            addr_a = ADDR_W'(r_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_y);
            addr_b = ADDR_W'(r_y) * ADDR_W'(MAX_DIM) + ADDR_W'(r_col);
        end else begin
            addr_a = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
            addr_b = addr_a;
        end
    end

    mmdp_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_re    (run_re),
        .i_addr  (addr_a),
        .i_wdata (elem_wdata),
        .o_rdata (rdata_a)
    );

    mmdp_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_re    (run_re),
        .i_addr  (addr_b),
        .i_wdata (elem_wdata),
        .o_rdata (rdata_b)
    );

    // ---------------------------------------------------------------
    // Multiply-accumulate
    // ---------------------------------------------------------------
    t_mac_ctl          mac_ctl;
    logic [PROD_W-1:0] mac_acc;

    assign mac_ctl.clr  = req_prod;
    assign mac_ctl.vld  = r_rd_vld;
    assign mac_ctl.last = r_rd_last;

    mmdp_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    // ---------------------------------------------------------------
    // Output register: result waits here while the next request enters
    // ---------------------------------------------------------------
    logic              r_out_vld;
    logic [PROD_W-1:0] r_out_prod;
    logic [IDX_W-1:0]  r_out_row;
    logic [IDX_W-1:0]  r_out_col;
    logic              r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Accumulator was cleared on accept, so an error result carries zero
    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_prod <= mac_acc;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_err  <= r_err;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_col, r_out_row, r_out_prod};
    assign o_m_axis_tuser  = r_out_err;

endmodule

// ===== rtl/mmdp_chk.sv =====
module mmdp_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [mmdp_pkg::MODE_W-1:0]     i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [mmdp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser
);
    import mmdp_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Out-of-range result carries a zero product
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[PROD_W-1:0] == '0)
        else $error("range error with nonzero product");

    // No result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A product request blocks the input for at least the next cycle
    a_prod_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_PRODUCT
            |=> !o_s_axis_tready)
        else $error("input ready right after a product request");

endmodule

bind matrix_multiply_dot_product mmdp_chk u_mmdp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
